// ===== src/rhwt_pkg.sv =====
// ----------------------------------------------------------------------------
// rhwt_pkg: shared types and constants for the weekly trigger
// Year limits, schedule ranges, register indexes, stream packing.
// ----------------------------------------------------------------------------
package rhwt_pkg;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [11:0] YEAR_RECOVER = 12'd2020;
  localparam logic [11:0] YEAR_VALID   = 12'd2023;
  localparam logic [1:0]  ERR_LIMIT    = 2'd3;
  localparam logic [2:0]  DAYS         = 3'd7;
  localparam logic [4:0]  HOURS        = 5'd24;
  localparam logic [5:0]  MINUTES      = 6'd60;
  localparam logic [2:0]  NO_DAY       = 3'd7;

  localparam logic [2:0]  RST_DAY      = 3'd0;
  localparam logic [4:0]  RST_HOUR     = 5'd2;
  localparam logic [5:0]  RST_MINUTE   = 6'd0;
  localparam logic [31:0] RST_RETRY    = 32'd30000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCHED_DAY    = 2'd0,
    REG_SCHED_HOUR   = 2'd1,
    REG_SCHED_MINUTE = 2'd2,
    REG_RETRY        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [5:0]  read_minute;
    logic [4:0]  read_hour;
    logic [2:0]  read_day;
    logic [11:0] read_year;
    logic [11:0] probe_year;
    logic        probe_found;
    logic [31:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic [1:0] error_run;
    logic       clock_fail;
    logic       start_pulse;
  } result_t;

  function automatic logic [2:0] wrap_day(input logic [2:0] v);
    return (v >= DAYS) ? 3'(v - DAYS) : v;
  endfunction

  function automatic logic [4:0] wrap_hour(input logic [4:0] v);
    return (v >= HOURS) ? 5'(v - HOURS) : v;
  endfunction

  function automatic logic [5:0] wrap_minute(input logic [5:0] v);
    return (v >= MINUTES) ? 6'(v - MINUTES) : v;
  endfunction

endpackage

// ===== src/rtc_health_weekly_trigger.sv =====
// ----------------------------------------------------------------------------
// rtc_health_weekly_trigger: weekly start pulse with clock health tracking
//
// Input stream (in_*): one transfer per loop tick, carrying the ms time,
// the recovery probe result and the regular clock read. Output stream
// (out_*): one result per tick with start_pulse, clock_fail and error_run.
// Config channel (cfg_*): schedule day/hour/minute and retry interval,
// always ready; day, hour and minute are wrapped into range on write.
//
// A tick is captured in an input register, the health and schedule update
// runs combinationally between that register and the result register, so a
// result passes through both registers. Throughput is one tick per cycle
// while out_tready stays high, set by the combinational state update loop.
// When the receiver stalls, the result register holds and the input
// register takes one more tick; then in_tready drops until out_tready.
// Reset (rst_n low, synchronous) empties both registers, marks the clock
// faulty, clears the error run and held time, and loads the default
// schedule (Sunday 02:00, retry 30000 ms).
// ----------------------------------------------------------------------------
module rtc_health_weekly_trigger (
  input  logic                           clk,
  input  logic                           rst_n,
  // now_ms[31:0], probe_found[32], probe_year[44:33], read_year[56:45],
  // read_day[59:57], read_hour[64:60], read_minute[70:65], zero pad [71]
  input  logic [rhwt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // start_pulse[0], clock_fail[1], error_run[3:2], zero pad [7:4]
  output logic [rhwt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rhwt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rhwt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rhwt_pkg::*;

  logic [2:0]  sched_day_r;
  logic [4:0]  sched_hour_r;
  logic [5:0]  sched_minute_r;
  logic [31:0] retry_r;

  logic        in_valid_r;
  tick_t       tick_r;
  logic        out_valid_r;
  result_t     res_r;

  logic        clock_ok_r, clock_ok_nxt;
  logic [1:0]  bad_r, bad_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic [2:0]  held_day_r, held_day_nxt;
  logic [4:0]  held_hour_r, held_hour_nxt;
  logic [5:0]  held_minute_r, held_minute_nxt;
  logic [2:0]  fired_r, fired_nxt;
  result_t     res_nxt;

  logic        advance;
  logic        go_read;
  logic [31:0] elapsed;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r};
  assign elapsed    = tick_r.now_ms - mark_r;

  always_comb begin
    clock_ok_nxt    = clock_ok_r;
    bad_nxt         = bad_r;
    mark_nxt        = mark_r;
    held_day_nxt    = held_day_r;
    held_hour_nxt   = held_hour_r;
    held_minute_nxt = held_minute_r;
    fired_nxt       = fired_r;
    go_read         = 1'b1;

    // recovery attempt only while faulty and the retry interval is over
    if (!clock_ok_r) begin
      if (elapsed < retry_r) begin
        go_read = 1'b0;
      end else if (tick_r.probe_found && tick_r.probe_year >= YEAR_RECOVER) begin
        clock_ok_nxt = 1'b1;
        bad_nxt      = 2'd0;
      end else begin
        mark_nxt = tick_r.now_ms;
        go_read  = 1'b0;
      end
    end

    if (go_read) begin
      if (tick_r.read_year < YEAR_VALID) begin
        if (bad_nxt != ERR_LIMIT) begin
          bad_nxt = bad_nxt + 2'd1;
        end
        if (bad_nxt == ERR_LIMIT) begin
          clock_ok_nxt = 1'b0;
          mark_nxt     = tick_r.now_ms;
        end
      end else begin
        // new weekday re-arms the trigger
        if (tick_r.read_day != held_day_r) begin
          fired_nxt = NO_DAY;
        end
        held_day_nxt    = tick_r.read_day;
        held_hour_nxt   = tick_r.read_hour;
        held_minute_nxt = tick_r.read_minute;
        bad_nxt         = 2'd0;
        clock_ok_nxt    = 1'b1;
      end
    end

    res_nxt.start_pulse = 1'b0;
    if (clock_ok_nxt && held_day_nxt == sched_day_r && held_hour_nxt == sched_hour_r &&
        held_minute_nxt == sched_minute_r && fired_nxt != held_day_nxt) begin
      res_nxt.start_pulse = 1'b1;
      fired_nxt           = held_day_nxt;
    end
    res_nxt.clock_fail = !clock_ok_nxt || (bad_nxt == ERR_LIMIT);
    res_nxt.error_run  = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_day_r    <= RST_DAY;
      sched_hour_r   <= RST_HOUR;
      sched_minute_r <= RST_MINUTE;
      retry_r        <= RST_RETRY;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      clock_ok_r     <= 1'b0;
      bad_r          <= 2'd0;
      mark_r         <= 32'd0;
      held_day_r     <= 3'd0;
      held_hour_r    <= 5'd0;
      held_minute_r  <= 6'd0;
      fired_r        <= NO_DAY;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCHED_DAY:    sched_day_r    <= wrap_day(cfg_data[2:0]);
          REG_SCHED_HOUR:   sched_hour_r   <= wrap_hour(cfg_data[4:0]);
          REG_SCHED_MINUTE: sched_minute_r <= wrap_minute(cfg_data[5:0]);
          REG_RETRY:        retry_r        <= cfg_data;
          default: ;
        endcase
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          clock_ok_r    <= clock_ok_nxt;
          bad_r         <= bad_nxt;
          mark_r        <= mark_nxt;
          held_day_r    <= held_day_nxt;
          held_hour_r   <= held_hour_nxt;
          held_minute_r <= held_minute_nxt;
          fired_r       <= fired_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r <= tick_t'(in_tdata[$bits(tick_t)-1:0]);
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  a_pulse_healthy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.start_pulse |-> !res_r.clock_fail)
    else $error("start pulse while clock reported failed");

  a_run_limit_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.error_run == ERR_LIMIT |-> res_r.clock_fail)
    else $error("error run at limit without clock_fail");

  a_fire_latch: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_valid_r && res_nxt.start_pulse |=> fired_r == held_day_r)
    else $error("fired day not latched after start pulse");

  a_ok_no_limit: assert property (@(posedge clk) disable iff (!rst_n)
    clock_ok_r |-> bad_r != ERR_LIMIT)
    else $error("clock marked good with error run at limit");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rtc_health_weekly_trigger
// Drives loop ticks on the input stream and checks each result against a
// cycle-free model of clock health and weekly schedule logic, or a short
// directed table's expected row. The table covers recovery, the bad-read
// run, the weekday latch and out-of-range reads. Random phases run under
// several schedules; random stalls on both streams stop in the last phase.
// ----------------------------------------------------------------------------
module testbench;
  import rhwt_pkg::*;

  localparam int unsigned RUN_LIMIT       = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 170;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  rtc_health_weekly_trigger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Model copy of schedule and health state
  logic [2:0]  sch_wday;
  logic [4:0]  sch_hr;
  logic [5:0]  sch_min;
  logic [31:0] retry_gap;
  logic        clk_good;
  logic [1:0]  bad_run;
  logic [31:0] retry_from;
  logic [2:0]  hold_wday;
  logic [4:0]  hold_hr;
  logic [5:0]  hold_min;
  logic [2:0]  fired_wday;

  result_t     due_results[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          quiet       = 1'b0;
  logic [31:0] sim_ms      = '0;
  int unsigned bad_left    = 0;

  typedef struct {
    tick_t   tick;
    bit      typed;
    result_t want;
  } step_row_t;

  step_row_t plan[$];

  function automatic result_t predict_tick_result(input tick_t t);
    result_t     r;
    logic        go;
    logic [31:0] elapsed;
    r       = '0;
    go      = clk_good;
    elapsed = t.now_ms - retry_from;
    if (!clk_good && elapsed >= retry_gap) begin
      if (t.probe_found && t.probe_year >= YEAR_RECOVER) begin
        clk_good = 1'b1;
        bad_run  = '0;
        go       = 1'b1;
      end else begin
        retry_from = t.now_ms;
      end
    end
    if (go) begin
      if (t.read_year < YEAR_VALID) begin
        if (bad_run != ERR_LIMIT) bad_run = bad_run + 2'd1;
        if (bad_run == ERR_LIMIT) begin
          clk_good   = 1'b0;
          retry_from = t.now_ms;
        end
      end else begin
        // a new weekday rearms the weekly latch
        if (t.read_day != hold_wday) fired_wday = NO_DAY;
        hold_wday = t.read_day;
        hold_hr   = t.read_hour;
        hold_min  = t.read_minute;
        bad_run   = '0;
        clk_good  = 1'b1;
      end
    end
    if (clk_good && hold_wday == sch_wday && hold_hr == sch_hr && hold_min == sch_min &&
        fired_wday != hold_wday) begin
      r.start_pulse = 1'b1;
      fired_wday    = hold_wday;
    end
    r.clock_fail = !clk_good || bad_run == ERR_LIMIT;
    r.error_run  = bad_run;
    return r;
  endfunction

  function automatic void add_step(input logic [31:0] now, input logic found,
                                   input logic [11:0] pyear, input logic [11:0] ryear,
                                   input logic [2:0] day, input logic [4:0] hr,
                                   input logic [5:0] mn, input bit typed,
                                   input logic p, input logic f, input logic [1:0] e);
    step_row_t r;
    r.tick.now_ms           = now;
    r.tick.probe_found      = found;
    r.tick.probe_year       = pyear;
    r.tick.read_year        = ryear;
    r.tick.read_day         = day;
    r.tick.read_hour        = hr;
    r.tick.read_minute      = mn;
    r.typed                 = typed;
    r.want.start_pulse      = p;
    r.want.clock_fail       = f;
    r.want.error_run        = e;
    plan.push_back(r);
  endfunction

  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) sim_ms = $urandom();
    else if (pick < 15) sim_ms = sim_ms + $urandom_range(20000, 40000);
    else sim_ms = sim_ms + $urandom_range(1, 3000);
    t.now_ms      = sim_ms;
    t.probe_found = ($urandom_range(0, 3) != 0);
    t.probe_year  = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(2020, 4095))
                                               : 12'($urandom_range(0, 2019));
    // bursts of bad reads push the clock into the faulty state
    if (bad_left == 0 && $urandom_range(0, 24) == 0) bad_left = $urandom_range(3, 4);
    if (bad_left != 0 || $urandom_range(0, 11) == 0) begin
      t.read_year = 12'($urandom_range(0, 2022));
      if (bad_left != 0) bad_left--;
    end else begin
      t.read_year = 12'($urandom_range(2023, 4095));
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      t.read_day    = sch_wday;
      t.read_hour   = sch_hr;
      t.read_minute = sch_min;
    end else if (pick < 40) begin
      t.read_day    = 3'($urandom_range(0, 7));
      t.read_hour   = 5'($urandom_range(0, 31));
      t.read_minute = 6'($urandom_range(0, 63));
    end else begin
      t.read_day    = 3'($urandom_range(0, 6));
      t.read_hour   = 5'($urandom_range(0, 23));
      t.read_minute = 6'($urandom_range(0, 59));
    end
    return t;
  endfunction

  task automatic push_tick(input tick_t t, input bit typed, input result_t want);
    result_t predicted;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tdata  <= IN_DATA_W'(t);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_tick_result(t);
    due_results.push_back(typed ? want : predicted);
  endtask

  // Hold the sender until the pipeline has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last transfer
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCHED_DAY:    sch_wday  = val[2:0] % DAYS;
      REG_SCHED_HOUR:   sch_hr    = val[4:0] % HOURS;
      REG_SCHED_MINUTE: sch_min   = val[5:0] % MINUTES;
      REG_RETRY:        retry_gap = val;
      default: ;
    endcase
  endtask

  task automatic set_schedule(input logic [31:0] d, input logic [31:0] h,
                              input logic [31:0] m, input logic [31:0] r);
    write_reg(REG_SCHED_DAY, d);
    write_reg(REG_SCHED_HOUR, h);
    write_reg(REG_SCHED_MINUTE, m);
    write_reg(REG_RETRY, r);
    cfg_valid <= 1'b0;
  endtask

  always begin
    @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[3:0]);
      if (due_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %b with nothing pending", got);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("mismatch: start_pulse %0d/%0d clock_fail %0d/%0d error_run %0d/%0d",
                     want.start_pulse, got.start_pulse, want.clock_fail, got.clock_fail,
                     want.error_run, got.error_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sch_wday   = RST_DAY;
    sch_hr     = RST_HOUR;
    sch_min    = RST_MINUTE;
    retry_gap  = RST_RETRY;
    clk_good   = 1'b0;
    bad_run    = '0;
    retry_from = '0;
    hold_wday  = '0;
    hold_hr    = '0;
    hold_min   = '0;
    fired_wday = NO_DAY;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // faulty after reset: too early, failed probe, too early, old year, then recovery
    add_step(32'd100,    1, 12'd2024, 12'd2024, 3'd0, 5'd2,  6'd0,  1, 0, 1, 2'd0);
    add_step(32'd30000,  0, 12'd4095, 12'd2024, 3'd0, 5'd2,  6'd0,  1, 0, 1, 2'd0);
    add_step(32'd40000,  1, 12'd2024, 12'd2024, 3'd0, 5'd2,  6'd0,  1, 0, 1, 2'd0);
    add_step(32'd60000,  1, 12'd2019, 12'd2024, 3'd0, 5'd2,  6'd0,  1, 0, 1, 2'd0);
    add_step(32'd90000,  1, 12'd2020, 12'd2023, 3'd0, 5'd2,  6'd0,  1, 1, 0, 2'd0);
    // same slot again must not refire
    add_step(32'd90010,  0, 12'd0,    12'd2023, 3'd0, 5'd2,  6'd0,  1, 0, 0, 2'd0);
    // three bad reads in a row
    add_step(32'd90020,  0, 12'd0,    12'd2022, 3'd0, 5'd2,  6'd0,  1, 0, 0, 2'd1);
    add_step(32'd90030,  0, 12'd0,    12'd0,    3'd0, 5'd2,  6'd0,  1, 0, 0, 2'd2);
    add_step(32'd90040,  0, 12'd0,    12'd2022, 3'd0, 5'd2,  6'd0,  1, 0, 1, 2'd3);
    add_step(32'd90041,  1, 12'd4095, 12'd2023, 3'd0, 5'd2,  6'd0,  1, 0, 1, 2'd3);
    add_step(32'd120040, 1, 12'd4095, 12'd4095, 3'd1, 5'd23, 6'd59, 1, 0, 0, 2'd0);
    // weekday change rearms the latch, out-of-range time never matches
    add_step(32'd120050, 0, 12'd0,    12'd2023, 3'd0, 5'd2,  6'd0,  1, 1, 0, 2'd0);
    add_step(32'd120060, 0, 12'd0,    12'd3000, 3'd7, 5'd31, 6'd63, 1, 0, 0, 2'd0);
    add_step(32'd120070, 0, 12'd0,    12'd2023, 3'd0, 5'd2,  6'd0,  1, 1, 0, 2'd0);
    add_step(32'd120080, 0, 12'd0,    12'd2023, 3'd0, 5'd2,  6'd1,  0, 0, 0, 2'd0);
    // retry interval across the 2^32 wrap of the ms time
    add_step(32'hFFFF_FF00, 0, 12'd0, 12'd2022, 3'd0, 5'd2,  6'd1,  0, 0, 0, 2'd0);
    add_step(32'hFFFF_FF10, 0, 12'd0, 12'd2022, 3'd0, 5'd2,  6'd1,  0, 0, 0, 2'd0);
    add_step(32'hFFFF_FF20, 0, 12'd0, 12'd2022, 3'd0, 5'd2,  6'd1,  0, 0, 0, 2'd0);
    add_step(32'h0000_7000, 1, 12'd2020, 12'd2023, 3'd0, 5'd2, 6'd0, 0, 0, 0, 2'd0);
    add_step(32'h0000_7700, 1, 12'd2020, 12'd2023, 3'd0, 5'd2, 6'd0, 0, 0, 0, 2'd0);
    add_step(32'h0000_7710, 0, 12'd0,    12'd2023, 3'd6, 5'd0, 6'd0, 0, 0, 0, 2'd0);
    add_step(32'hFFFF_FFFF, 1, 12'hFFF,  12'hFFF,  3'd7, 5'd31, 6'd63, 0, 0, 0, 2'd0);
    add_step(32'd0,         0, 12'd0,    12'd0,    3'd0, 5'd0,  6'd0,  0, 0, 0, 2'd0);
    foreach (plan[i]) push_tick(plan[i].tick, plan[i].typed, plan[i].want);
    sim_ms = 32'd200000;

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: set_schedule(32'd6, 32'd23, 32'd59, 32'd0);
        1: set_schedule(32'd7, 32'd31, 32'd63, 32'hFFFF_FFFF);
        2: set_schedule(32'd0, 32'd0, 32'd0, 32'd1000);
        3: set_schedule($urandom(), $urandom(), $urandom(), $urandom_range(0, 60000));
        default: begin
          quiet = 1'b1;
          set_schedule(32'd3, 32'd12, 32'd30, RST_RETRY);
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_tick(random_tick(), 1'b0, '0);
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
